// File: hdl/ial_pkg.sv
package ial_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int WORD_W = 32;

    typedef enum logic [2:0] {
        ACT_READ   = 3'd0,
        ACT_INSERT = 3'd1,
        ACT_EDIT   = 3'd2,
        ACT_REMOVE = 3'd3,
        ACT_BSRCH  = 3'd4,
        ACT_LSRCH  = 3'd5,
        ACT_SORT   = 3'd6,
        ACT_NONE   = 3'd7
    } action_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_INDEX = 2'd1,
        ST_OVERFLOW  = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        OP_HOLD  = 2'd0,
        OP_WRITE = 2'd1,
        OP_SHUP  = 2'd2,
        OP_SHDN  = 2'd3
    } cell_op_t;

    typedef struct packed {
        cell_op_t    op;
        logic        sort_even;
        logic        sort_odd;
        logic [31:0] wdata;
    } cell_ctl_t;

endpackage

// File: hdl/ial_cell.sv
module ial_cell (
    input  logic              clk,
    input  ial_pkg::cell_ctl_t ctl,
    input  logic              sel,
    input  logic              shift_en,
    input  logic              pair_lo,
    input  logic              pair_hi,
    input  logic [31:0]       left_word,
    input  logic [31:0]       right_word,
    output logic [31:0]       word
);
    import ial_pkg::*;

    logic [31:0] word_reg;
    logic [31:0] word_next;
    logic        swap_lo;
    logic        swap_hi;

    assign swap_lo = pair_lo && ($signed(word_reg) > $signed(right_word));
    assign swap_hi = pair_hi && ($signed(left_word) > $signed(word_reg));

    always_comb
    begin
        word_next = word_reg;
        case (ctl.op)
            OP_WRITE:
            begin
                if (sel)
                    word_next = ctl.wdata;
            end
            OP_SHUP:
            begin
                if (sel)
                    word_next = ctl.wdata;
                else if (shift_en)
                    word_next = left_word;
            end
            OP_SHDN:
            begin
                if (shift_en)
                    word_next = right_word;
            end
            default:
            begin
                if (swap_lo)
                    word_next = right_word;
                else if (swap_hi)
                    word_next = left_word;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word = word_reg;
endmodule

// File: hdl/indexed_array_list_engine_top.sv
// Indexed array list engine: a bounded list of signed 32-bit words.
// Requests arrive as beats on the input channel (action, index, data_value)
// and each gives exactly one result beat (status, read_value,
// found_position, item_count) on the output channel.
// The words live in a row of cells; each cell holds one word and can take
// its neighbor's word, so insert and remove shift the words from the
// index upward at once.
// Read, insert, edit, remove and linear search pass through S_EXEC and
// S_DONE to the output register; a new request is taken only in S_IDLE.
// Binary search makes up to log2(DEPTH)+1 probes in S_BSRCH, plus a
// closing step there when nothing matches. Sort runs DEPTH odd-even
// transposition passes in S_SORT over the occupied cells.
// One request is handled at a time; a new input beat is taken once the
// previous result has been moved into the output register, so the block
// can accept while a result waits to be taken.
// If the receiver stalls, the result holds in the output register and
// at most one further request waits in progress.
// Reset clears the count to zero and capacity_limit to 16; word contents
// are undefined until written. Inserts see capacity_limit saturated at DEPTH.
module indexed_array_list_engine_top #(
    parameter int DEPTH = ial_pkg::DEPTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  action,
    input  logic [4:0]  index,
    input  logic signed [31:0] data_value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic signed [31:0] read_value,
    output logic [3:0]  found_position,
    output logic [4:0]  item_count
);
    import ial_pkg::*;

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_EXEC  = 5'b00010,
        S_BSRCH = 5'b00100,
        S_SORT  = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [4:0]  cap_reg;
    logic [CW-1:0] count_reg, count_next;
    action_t     act_reg;
    logic [4:0]  idx_reg;
    logic [31:0] val_reg;
    logic [CW:0] lo_reg, lo_next, hi_reg, hi_next;
    logic [CW-1:0] pass_reg, pass_next;
    logic [1:0]  res_st_reg, res_st_next;
    logic [31:0] res_rd_reg, res_rd_next;
    logic [3:0]  res_pos_reg, res_pos_next;

    logic        ov_reg;
    logic [1:0]  ov_st_reg;
    logic [31:0] ov_rd_reg;
    logic [3:0]  ov_pos_reg;
    logic [4:0]  ov_cnt_reg;

    cell_ctl_t   ctl;
    logic [31:0] words [DEPTH];
    logic [DEPTH-1:0] match;
    logic [IW-1:0] first_idx;
    logic        any_match;
    logic [CW:0] cap_sat;
    logic        idx_lt_cnt;
    logic        idx_le_cnt;
    logic [CW:0] mid;
    logic [31:0] mid_word;

    assign pready = 1'b1;
    assign prdata = {27'd0, cap_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cap_reg <= 5'd16;
        else if (psel && penable && pwrite && paddr == 2'd0)
            cap_reg <= pwdata[4:0];
    end

    assign cap_sat    = (32'(cap_reg) > 32'(DEPTH)) ? (CW+1)'(DEPTH) : (CW+1)'(cap_reg);
    assign idx_lt_cnt = 32'(idx_reg) < 32'(count_reg);
    assign idx_le_cnt = 32'(idx_reg) <= 32'(count_reg);
    assign mid        = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign mid_word   = words[mid[IW-1:0]];

    always_comb
    begin
        match     = '0;
        first_idx = '0;
        any_match = 1'b0;
        for (int k = DEPTH - 1; k >= 0; k--)
        begin
            match[k] = (32'(k) < 32'(count_reg)) && (words[k] == val_reg);
            if (match[k])
            begin
                first_idx = IW'(k);
                any_match = 1'b1;
            end
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        pass_next    = pass_reg;
        res_st_next  = res_st_reg;
        res_rd_next  = res_rd_reg;
        res_pos_next = res_pos_reg;
        ctl.op        = OP_HOLD;
        ctl.sort_even = 1'b0;
        ctl.sort_odd  = 1'b0;
        ctl.wdata     = val_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                res_st_next  = ST_OK;
                res_rd_next  = '0;
                res_pos_next = '0;
                state_next   = S_DONE;
                case (act_reg)
                    ACT_READ:
                    begin
                        if (idx_lt_cnt)
                            res_rd_next = words[IW'(idx_reg)];
                        else
                            res_st_next = ST_BAD_INDEX;
                    end
                    ACT_INSERT:
                    begin
                        if ((CW+1)'(count_reg) >= cap_sat)
                            res_st_next = ST_OVERFLOW;
                        else if (!idx_le_cnt)
                            res_st_next = ST_BAD_INDEX;
                        else
                        begin
                            ctl.op     = OP_SHUP;
                            count_next = count_reg + 1'b1;
                        end
                    end
                    ACT_EDIT:
                    begin
                        if (idx_lt_cnt)
                            ctl.op = OP_WRITE;
                        else
                            res_st_next = ST_BAD_INDEX;
                    end
                    ACT_REMOVE:
                    begin
                        if (idx_lt_cnt)
                        begin
                            ctl.op     = OP_SHDN;
                            count_next = count_reg - 1'b1;
                        end
                        else
                            res_st_next = ST_BAD_INDEX;
                    end
                    ACT_BSRCH:
                    begin
                        lo_next    = '0;
                        hi_next    = (CW+1)'(count_reg) - 1'b1;
                        state_next = S_BSRCH;
                    end
                    ACT_LSRCH:
                    begin
                        if (any_match)
                            res_pos_next = 4'(first_idx);
                        else
                            res_st_next = ST_NOT_FOUND;
                    end
                    ACT_SORT:
                    begin
                        pass_next  = '0;
                        state_next = S_SORT;
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_BSRCH:
            begin
                if ($signed(lo_reg) > $signed(hi_reg))
                begin
                    res_st_next = ST_NOT_FOUND;
                    state_next  = S_DONE;
                end
                else if (mid_word == val_reg)
                begin
                    res_pos_next = 4'(mid);
                    state_next   = S_DONE;
                end
                else if ($signed(mid_word) > $signed(val_reg))
                    hi_next = mid - 1'b1;
                else
                    lo_next = mid + 1'b1;
            end
            S_SORT:
            begin
                ctl.sort_even = ~pass_reg[0];
                ctl.sort_odd  = pass_reg[0];
                pass_next     = pass_reg + 1'b1;
                if (32'(pass_reg) == DEPTH - 1)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!ov_reg || out_ready)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        logic pl;
        logic ph;
        logic sh;
        logic [31:0] lw;
        logic [31:0] rw;
        assign lw = (g == 0) ? words[0] : words[(g == 0) ? 0 : g - 1];
        assign rw = (g == DEPTH - 1) ? words[g] : words[(g == DEPTH - 1) ? g : g + 1];
        assign pl = (g < DEPTH - 1) && (32'(g + 1) < 32'(count_reg)) &&
                    ((g % 2 == 0) ? ctl.sort_even : ctl.sort_odd);
        assign ph = (g > 0) && (32'(g) < 32'(count_reg)) &&
                    ((g % 2 == 1) ? ctl.sort_even : ctl.sort_odd);
        assign sh = (ctl.op == OP_SHUP) ? (32'(g) > 32'(idx_reg)) :
                    (32'(g) >= 32'(idx_reg));
        ial_cell u_cell (
            .clk        (clk),
            .ctl        (ctl),
            .sel        (32'(g) == 32'(idx_reg)),
            .shift_en   (sh),
            .pair_lo    (pl),
            .pair_hi    (ph),
            .left_word  (lw),
            .right_word (rw),
            .word       (words[g])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (state_reg == S_DONE && (!ov_reg || out_ready))
                ov_reg <= 1'b1;
            else if (out_ready)
                ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        pass_reg    <= pass_next;
        res_st_reg  <= res_st_next;
        res_rd_reg  <= res_rd_next;
        res_pos_reg <= res_pos_next;
        if (in_valid && in_ready)
        begin
            act_reg <= action_t'(action);
            idx_reg <= index;
            val_reg <= data_value;
        end
        if (state_reg == S_DONE && (!ov_reg || out_ready))
        begin
            ov_st_reg  <= res_st_reg;
            ov_rd_reg  <= res_rd_reg;
            ov_pos_reg <= res_pos_reg;
            ov_cnt_reg <= 5'(count_reg);
        end
    end

    assign out_valid      = ov_reg;
    assign status         = ov_st_reg;
    assign read_value     = ov_rd_reg;
    assign found_position = ov_pos_reg;
    assign item_count     = ov_cnt_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= DEPTH)
        else $error("count beyond depth");
    a_insert_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC && ctl.op == OP_SHUP) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("insert did not grow count");
    a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !in_ready)
        else $error("accept while busy");
endmodule

// File: tb/indexed_array_list_engine_top_test.sv
module indexed_array_list_engine_top_test;
    import ial_pkg::*;

    localparam int NSLOT = 16;
    localparam int CYCLE_LIMIT = 1500000;
    localparam int SETTLE_CYCLES = 40;
    localparam logic [1:0] REG_CAPACITY = 2'd0;

    typedef struct packed {
        status_t            st;
        logic signed [31:0] rd;
        logic [3:0]         pos;
        logic [4:0]         cnt;
    } answer_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [2:0] action = '0;
    logic [4:0] index = '0;
    logic signed [31:0] data_value = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [1:0] status;
    logic signed [31:0] read_value;
    logic [3:0] found_position;
    logic [4:0] item_count;

    logic signed [31:0] list_words [NSLOT];
    int list_len;
    int cap_reg;
    answer_t answers_due [$];
    int mismatches;
    int cycles;
    int stall_left = 0;
    bit quiet;

    indexed_array_list_engine_top dut (.*);

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("indexed_array_list_engine_top regression: fail");
            $finish;
        end
    end

    function automatic answer_t apply_request(action_t act, int idx, logic signed [31:0] val);
        answer_t a;
        int usable;
        int lo;
        int hi;
        int mid;
        logic signed [31:0] t;
        a = '{ST_OK, 32'sd0, 4'd0, 5'd0};
        usable = (cap_reg > NSLOT) ? NSLOT : cap_reg;
        case (act)
            ACT_READ:
                if (idx < list_len) a.rd = list_words[idx];
                else a.st = ST_BAD_INDEX;
            ACT_INSERT:
                if (list_len >= usable) a.st = ST_OVERFLOW;
                else if (idx > list_len) a.st = ST_BAD_INDEX;
                else
                begin
                    for (int i = list_len; i > idx; i--) list_words[i] = list_words[i-1];
                    list_words[idx] = val;
                    list_len++;
                end
            ACT_EDIT:
                if (idx < list_len) list_words[idx] = val;
                else a.st = ST_BAD_INDEX;
            ACT_REMOVE:
                if (idx < list_len)
                begin
                    for (int i = idx; i + 1 < list_len; i++) list_words[i] = list_words[i+1];
                    list_len--;
                end
                else a.st = ST_BAD_INDEX;
            ACT_BSRCH:
            begin
                a.st = ST_NOT_FOUND;
                lo = 0;
                hi = list_len - 1;
                while (lo <= hi && a.st == ST_NOT_FOUND)
                begin
                    mid = lo + (hi - lo) / 2;
                    if (list_words[mid] == val)
                    begin
                        a.st = ST_OK;
                        a.pos = mid[3:0];
                    end
                    else if (list_words[mid] > val) hi = mid - 1;
                    else lo = mid + 1;
                end
            end
            ACT_LSRCH:
            begin
                a.st = ST_NOT_FOUND;
                for (int i = list_len - 1; i >= 0; i--)
                    if (list_words[i] == val)
                    begin
                        a.st = ST_OK;
                        a.pos = i[3:0];
                    end
            end
            ACT_SORT:
                for (int r = 1; r < list_len; r++)
                    for (int i = 0; i + r < list_len; i++)
                        if (list_words[i] > list_words[i+1])
                        begin
                            t = list_words[i];
                            list_words[i] = list_words[i+1];
                            list_words[i+1] = t;
                        end
            default: ;
        endcase
        a.cnt = list_len[4:0];
        return a;
    endfunction

    task automatic idle_burst();
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    endtask

    task automatic send_request(action_t act, int idx, logic signed [31:0] val);
        idle_burst();
        in_valid <= 1'b1;
        action <= act;
        index <= idx[4:0];
        data_value <= val;
        do @(posedge clk); while (!in_ready);
        answers_due.push_back(apply_request(act, idx, val));
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (answers_due.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_capacity(int value);
        drain();
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= REG_CAPACITY;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        cap_reg = value & 31;
    endtask

    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            out_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (!quiet && $urandom_range(0, 5) == 0)
        begin
            out_ready <= 1'b0;
            stall_left <= $urandom_range(0, 11);
        end
        else
            out_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        answer_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (answers_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat");
            end
            else
            begin
                e = answers_due.pop_front();
                if (status !== e.st || read_value !== e.rd || found_position !== e.pos
                    || item_count !== e.cnt)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: exp st=%0d rd=%0d pos=%0d cnt=%0d ",
                                  "got st=%0d rd=%0d pos=%0d cnt=%0d"},
                            e.st, e.rd, e.pos, e.cnt, status, read_value, found_position,
                            item_count);
                end
            end
        end
    end

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 4))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return $urandom_range(0, 7) - 3;
            3: return (list_len > 0) ? list_words[$urandom_range(0, list_len - 1)] : 0;
            default: return $urandom;
        endcase
    endfunction

    task automatic random_request();
        action_t act;
        int idx;
        act = action_t'($urandom_range(0, 7));
        if ($urandom_range(0, 2) == 0) act = ACT_INSERT;
        if ($urandom_range(0, 5) == 0) idx = $urandom_range(0, 31);
        else idx = $urandom_range(0, list_len);
        send_request(act, idx, pick_value());
    endtask

    task automatic test_directed();
        send_request(ACT_READ, 0, 0);
        send_request(ACT_REMOVE, 0, 0);
        send_request(ACT_EDIT, 31, 5);
        send_request(ACT_BSRCH, 0, 1);
        send_request(ACT_LSRCH, 0, 1);
        send_request(ACT_SORT, 0, 0);
        send_request(ACT_INSERT, 1, 9);
        send_request(ACT_INSERT, 0, 32'sh7fff_ffff);
        send_request(ACT_INSERT, 0, 32'sh8000_0000);
        send_request(ACT_INSERT, 2, -1);
        send_request(ACT_INSERT, 1, 0);
        send_request(ACT_READ, 3, 0);
        send_request(ACT_READ, 4, 0);
        send_request(ACT_LSRCH, 0, -1);
        send_request(ACT_BSRCH, 0, -1);
        send_request(ACT_SORT, 0, 0);
        send_request(ACT_BSRCH, 0, 32'sh7fff_ffff);
        send_request(ACT_BSRCH, 0, 32'sh8000_0000);
        send_request(ACT_EDIT, 3, 32'sh5555_aaaa);
        send_request(ACT_REMOVE, 31, 0);
        send_request(ACT_REMOVE, 0, 0);
        send_request(ACT_NONE, 31, -1);
        send_request(ACT_READ, 0, 0);
    endtask

    task automatic test_capacity();
        write_capacity(2);
        send_request(ACT_INSERT, 0, 1);
        send_request(ACT_READ, 0, 0);
        write_capacity(0);
        send_request(ACT_INSERT, 0, 1);
        write_capacity(31);
        for (int i = 0; i < 20; i++) send_request(ACT_INSERT, 0, i);
        send_request(ACT_INSERT, 0, 7);
        write_capacity(1);
    endtask

    task automatic test_random(int n);
        for (int i = 0; i < n; i++)
        begin
            random_request();
            if (i == n / 2) drain();
        end
    endtask

    initial
    begin
        mismatches = 0;
        cycles = 0;
        quiet = 0;
        list_len = 0;
        cap_reg = 16;
        for (int i = 0; i < NSLOT; i++) list_words[i] = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_capacity();
        write_capacity(16);
        test_random(600);
        write_capacity(5);
        test_random(400);
        write_capacity(1);
        test_random(150);
        write_capacity(16);
        test_random(500);
        quiet = 1;
        test_random(250);
        drain();
        if (mismatches == 0)
            $display("indexed_array_list_engine_top regression: pass");
        else
            $display("indexed_array_list_engine_top regression: fail");
        $finish;
    end
endmodule

// File: sim.f
hdl/ial_pkg.sv
hdl/ial_cell.sv
hdl/indexed_array_list_engine_top.sv
tb/indexed_array_list_engine_top_test.sv
